// File: rtl/core/svpwm_pkg.sv
package svpwm_pkg;

    localparam int FIELD_W     = 32;
    localparam int CFG_W       = 31;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_W-1:0] PERIOD_RESET   = 31'd1677721600;
    localparam logic [CFG_W-1:0] GAIN_RESET     = 31'd242158254;
    // sqrt3/2 in q30
    localparam logic [CFG_W-1:0] SQRT3_HALF_Q30 = 31'd929887697;

    typedef logic [0:0] cfg_index_t;
    localparam cfg_index_t REG_PERIOD = 1'b0;
    localparam cfg_index_t REG_GAIN   = 1'b1;

    typedef logic [2:0] sector_t;
    localparam sector_t SECTOR_NONE = 3'd0;

    typedef struct packed {
        logic signed [FIELD_W-1:0] volt_alpha;
        logic signed [FIELD_W-1:0] volt_beta;
    } in_item_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] phase_a_time;
        logic signed [FIELD_W-1:0] phase_b_time;
        logic signed [FIELD_W-1:0] phase_c_time;
        sector_t                   sector_out;
    } out_item_t;

    // classified item handed from front to back, axis values sign extended
    typedef struct packed {
        sector_t                   sector;
        logic signed [FIELD_W-1:0] u1;
        logic signed [FIELD_W-1:0] u2;
        logic signed [FIELD_W-1:0] u3;
    } queue_entry_t;

    typedef enum logic [1:0] {
        AXIS_U1,
        AXIS_U2,
        AXIS_U3
    } axis_t;

    typedef struct packed {
        axis_t x_axis;
        axis_t y_axis;
        logic  negate;
    } sector_sel_t;

    typedef enum logic [1:0] {
        PH_FULL,
        PH_ACTIVE_Y,
        PH_ZERO
    } phase_src_t;

    typedef struct packed {
        phase_src_t a;
        phase_src_t b;
        phase_src_t c;
    } phase_route_t;

    // sign code is {u3 > 0, u2 > 0, u1 > 0}
    function automatic sector_t code_to_sector(logic [2:0] code);
        sector_t s;
        unique case (code)
            3'b011:  s = 3'd1;
            3'b001:  s = 3'd2;
            3'b101:  s = 3'd3;
            3'b100:  s = 3'd4;
            3'b110:  s = 3'd5;
            3'b010:  s = 3'd6;
            default: s = SECTOR_NONE;
        endcase
        return s;
    endfunction

    function automatic sector_sel_t sector_select(sector_t s);
        sector_sel_t sel;
        unique case (s)
            3'd1:    sel = '{x_axis: AXIS_U2, y_axis: AXIS_U1, negate: 1'b0};
            3'd2:    sel = '{x_axis: AXIS_U2, y_axis: AXIS_U3, negate: 1'b1};
            3'd3:    sel = '{x_axis: AXIS_U1, y_axis: AXIS_U3, negate: 1'b0};
            3'd4:    sel = '{x_axis: AXIS_U1, y_axis: AXIS_U2, negate: 1'b1};
            3'd5:    sel = '{x_axis: AXIS_U3, y_axis: AXIS_U2, negate: 1'b0};
            3'd6:    sel = '{x_axis: AXIS_U3, y_axis: AXIS_U1, negate: 1'b1};
            default: sel = '{x_axis: AXIS_U1, y_axis: AXIS_U1, negate: 1'b0};
        endcase
        return sel;
    endfunction

    function automatic phase_route_t phase_route(sector_t s);
        phase_route_t r;
        unique case (s)
            3'd1:    r = '{a: PH_FULL,     b: PH_ACTIVE_Y, c: PH_ZERO};
            3'd2:    r = '{a: PH_ACTIVE_Y, b: PH_FULL,     c: PH_ZERO};
            3'd3:    r = '{a: PH_ZERO,     b: PH_FULL,     c: PH_ACTIVE_Y};
            3'd4:    r = '{a: PH_ZERO,     b: PH_ACTIVE_Y, c: PH_FULL};
            3'd5:    r = '{a: PH_ACTIVE_Y, b: PH_ZERO,     c: PH_FULL};
            3'd6:    r = '{a: PH_FULL,     b: PH_ZERO,     c: PH_ACTIVE_Y};
            default: r = '{a: PH_ZERO,     b: PH_ZERO,     c: PH_ZERO};
        endcase
        return r;
    endfunction

endpackage

// File: rtl/core/svpwm_front.sv
module svpwm_front #(
    parameter int FRAC_BITS  = 24,
    parameter int DATA_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  svpwm_pkg::in_item_t     in_item,
    output logic                    push_valid,
    input  logic                    push_ready,
    output svpwm_pkg::queue_entry_t push_entry
);
    import svpwm_pkg::*;

    localparam int W      = DATA_WIDTH;
    localparam int PROD_W = DATA_WIDTH + FIELD_W;
    localparam logic signed [FIELD_W-1:0] SQRT3_HALF =
        FIELD_W'(SQRT3_HALF_Q30 >> (30 - FRAC_BITS));

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_PUSH
    } state_t;

    state_t                   state_reg;
    logic signed [W-1:0]      alpha_reg;
    logic signed [W-1:0]      beta_reg;
    logic signed [PROD_W-1:0] mul_reg;
    sector_t                  held_sector_reg;

    logic signed [PROD_W-1:0] mul_wide;
    logic signed [W-1:0]      alpha_proj;
    logic signed [W-1:0]      beta_half;
    logic signed [W-1:0]      u1;
    logic signed [W-1:0]      u2;
    logic signed [W-1:0]      u3;
    logic [2:0]               sign_code;
    sector_t                  found_sector;
    sector_t                  sector_next;

    assign mul_wide   = alpha_reg * SQRT3_HALF;
    assign alpha_proj = mul_reg[FRAC_BITS +: W];
    assign beta_half  = beta_reg >>> 1;
    assign u1         = beta_reg;
    assign u2         = alpha_proj - beta_half;
    assign u3         = -alpha_proj - beta_half;

    assign sign_code = {(!u3[W-1] && (u3 != '0)),
                        (!u2[W-1] && (u2 != '0)),
                        (!u1[W-1] && (u1 != '0))};
    assign found_sector = code_to_sector(sign_code);
    // ambiguous codes keep the sector we already have
    assign sector_next  = (found_sector != SECTOR_NONE) ? found_sector : held_sector_reg;

    assign push_valid        = (state_reg == F_PUSH);
    assign push_entry.sector = sector_next;
    assign push_entry.u1     = FIELD_W'(u1);
    assign push_entry.u2     = FIELD_W'(u2);
    assign push_entry.u3     = FIELD_W'(u3);

    assign in_ready = (state_reg == F_IDLE) || ((state_reg == F_PUSH) && push_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= F_IDLE;
            alpha_reg       <= '0;
            beta_reg        <= '0;
            mul_reg         <= '0;
            held_sector_reg <= SECTOR_NONE;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (in_valid)
                    begin
                        alpha_reg <= in_item.volt_alpha[W-1:0];
                        beta_reg  <= in_item.volt_beta[W-1:0];
                        state_reg <= F_MUL;
                    end
                end
                F_MUL:
                begin
                    mul_reg   <= mul_wide;
                    state_reg <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (push_ready)
                    begin
                        held_sector_reg <= sector_next;
                        if (in_valid)
                        begin
                            alpha_reg <= in_item.volt_alpha[W-1:0];
                            beta_reg  <= in_item.volt_beta[W-1:0];
                            state_reg <= F_MUL;
                        end
                        else
                        begin
                            state_reg <= F_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    // once a sector is found it is never lost again
    assert property (@(posedge clk) disable iff (!rst_n)
        (held_sector_reg != SECTOR_NONE) |=> (held_sector_reg != SECTOR_NONE))
        else $error("held sector fell back to none");

endmodule

// File: rtl/core/svpwm_queue.sv
module svpwm_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push_valid,
    output logic                    push_ready,
    input  svpwm_pkg::queue_entry_t push_entry,
    output logic                    pop_valid,
    input  logic                    pop_ready,
    output svpwm_pkg::queue_entry_t pop_entry
);
    import svpwm_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

    queue_entry_t     entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    logic do_push;
    logic do_pop;

    assign push_ready = (count_reg != DEPTH_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= DEPTH_CNT)
        else $error("queue fill count beyond depth");

endmodule

// File: rtl/core/svpwm_back.sv
module svpwm_back #(
    parameter int FRAC_BITS  = 24,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic signed [DATA_WIDTH-1:0] period_time,
    input  logic signed [DATA_WIDTH-1:0] time_gain,
    input  logic                         pop_valid,
    output logic                         pop_ready,
    input  svpwm_pkg::queue_entry_t      pop_entry,
    output logic                         out_valid,
    input  logic                         out_ready,
    output svpwm_pkg::out_item_t         out_item
);
    import svpwm_pkg::*;

    localparam int W      = DATA_WIDTH;
    localparam int PROD_W = DATA_WIDTH + FIELD_W;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MX,
        B_MY,
        B_T7,
        B_OUT
    } state_t;

    state_t                   state_reg;
    sector_t                  sector_reg;
    logic signed [W-1:0]      u1_reg;
    logic signed [W-1:0]      u2_reg;
    logic signed [W-1:0]      u3_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [W-1:0]      x_reg;
    logic signed [W-1:0]      y_reg;
    logic signed [W-1:0]      t7_reg;
    logic signed [W-1:0]      held_a_reg;
    logic signed [W-1:0]      held_b_reg;
    logic signed [W-1:0]      held_c_reg;
    out_item_t                out_item_reg;
    logic                     out_valid_reg;

    sector_sel_t              sel;
    phase_route_t             route;
    logic signed [W-1:0]      u_x;
    logic signed [W-1:0]      u_y;
    logic signed [W-1:0]      u_mul;
    logic signed [PROD_W-1:0] prod_wide;
    logic signed [W-1:0]      q_scaled;
    logic signed [W-1:0]      q_signed;
    logic signed [W-1:0]      zero_diff;
    logic signed [W-1:0]      sum_full;
    logic signed [W-1:0]      sum_y;
    logic signed [W-1:0]      ta;
    logic signed [W-1:0]      tb;
    logic signed [W-1:0]      tc;
    logic                     out_free;
    logic                     load_out;
    logic                     sector_known;

    assign sel          = sector_select(sector_reg);
    assign route        = phase_route(sector_reg);
    assign out_free     = !out_valid_reg || out_ready;
    assign load_out     = (state_reg == B_OUT) && out_free;
    assign sector_known = (sector_reg != SECTOR_NONE);

    always_comb
    begin
        unique case (sel.x_axis)
            AXIS_U2: u_x = u2_reg;
            AXIS_U3: u_x = u3_reg;
            default: u_x = u1_reg;
        endcase
        unique case (sel.y_axis)
            AXIS_U2: u_y = u2_reg;
            AXIS_U3: u_y = u3_reg;
            default: u_y = u1_reg;
        endcase
    end

    // one shared multiplier, x on the first pass and y on the second
    assign u_mul     = (state_reg == B_MX) ? u_x : u_y;
    assign prod_wide = time_gain * u_mul;
    assign q_scaled  = prod_reg[FRAC_BITS +: W];
    assign q_signed  = sel.negate ? -q_scaled : q_scaled;
    assign zero_diff = period_time - x_reg - q_signed;
    assign sum_y     = y_reg + t7_reg;
    assign sum_full  = x_reg + sum_y;

    always_comb
    begin
        unique case (route.a)
            PH_FULL:     ta = sum_full;
            PH_ACTIVE_Y: ta = sum_y;
            default:     ta = t7_reg;
        endcase
        unique case (route.b)
            PH_FULL:     tb = sum_full;
            PH_ACTIVE_Y: tb = sum_y;
            default:     tb = t7_reg;
        endcase
        unique case (route.c)
            PH_FULL:     tc = sum_full;
            PH_ACTIVE_Y: tc = sum_y;
            default:     tc = t7_reg;
        endcase
    end

    assign pop_ready = (state_reg == B_IDLE) || ((state_reg == B_OUT) && out_free);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            sector_reg    <= SECTOR_NONE;
            u1_reg        <= '0;
            u2_reg        <= '0;
            u3_reg        <= '0;
            prod_reg      <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            t7_reg        <= '0;
            held_a_reg    <= '0;
            held_b_reg    <= '0;
            held_c_reg    <= '0;
            out_item_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE:
                begin
                    if (pop_valid)
                    begin
                        sector_reg <= pop_entry.sector;
                        u1_reg     <= pop_entry.u1[W-1:0];
                        u2_reg     <= pop_entry.u2[W-1:0];
                        u3_reg     <= pop_entry.u3[W-1:0];
                        state_reg  <= B_MX;
                    end
                end
                B_MX:
                begin
                    prod_reg  <= prod_wide;
                    state_reg <= B_MY;
                end
                B_MY:
                begin
                    x_reg     <= q_signed;
                    prod_reg  <= prod_wide;
                    state_reg <= B_T7;
                end
                B_T7:
                begin
                    y_reg     <= q_signed;
                    t7_reg    <= zero_diff >>> 1;
                    state_reg <= B_OUT;
                end
                B_OUT:
                begin
                    if (out_free)
                    begin
                        // no sector yet: keep handing out the held zeros
                        if (sector_known)
                        begin
                            held_a_reg <= ta;
                            held_b_reg <= tb;
                            held_c_reg <= tc;
                            out_item_reg.phase_a_time <= FIELD_W'(ta);
                            out_item_reg.phase_b_time <= FIELD_W'(tb);
                            out_item_reg.phase_c_time <= FIELD_W'(tc);
                        end
                        else
                        begin
                            out_item_reg.phase_a_time <= FIELD_W'(held_a_reg);
                            out_item_reg.phase_b_time <= FIELD_W'(held_b_reg);
                            out_item_reg.phase_c_time <= FIELD_W'(held_c_reg);
                        end
                        out_item_reg.sector_out <= sector_reg;
                        if (pop_valid)
                        begin
                            sector_reg <= pop_entry.sector;
                            u1_reg     <= pop_entry.u1[W-1:0];
                            u2_reg     <= pop_entry.u2[W-1:0];
                            u3_reg     <= pop_entry.u3[W-1:0];
                            state_reg  <= B_MX;
                        end
                        else
                        begin
                            state_reg <= B_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_MX) |-> (sector_reg <= 3'd6))
        else $error("sector code outside one to six");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_item_reg.sector_out == SECTOR_NONE)) |->
        ((out_item_reg.phase_a_time == '0) && (out_item_reg.phase_b_time == '0) &&
         (out_item_reg.phase_c_time == '0)))
        else $error("phase times not zero before first sector");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_OUT) |-> $past(state_reg == B_T7) || $past(state_reg == B_OUT))
        else $error("phase stage entered without zero time");

endmodule

// File: rtl/core/svpwm_duty_time_calc_core.sv
// Seven-segment space vector PWM timing: each item carries an alpha/beta voltage pair in
// signed Q format and yields one result with the three phase on-times and the sector in use.
// The front stage takes an item in, scales alpha by sqrt3/2 on its own multiplier and
// classifies the sector (ambiguous sign codes keep the last sector), then posts the axis
// values to a two-entry queue. The back stage computes both active vector times on one
// shared multiplier, then the zero time and the phase sums, with no overmodulation clamp:
// everything wraps at DATA_WIDTH bits. Until a first sector is found the results carry
// zero times and sector 0. The back stage works on one item at a time: two passes through
// its shared multiplier, then its zero time and phase sum steps; it takes the next item
// from the queue as it hands a result out, and the front can run ahead. Configuration is
// always accepted (cfg_ready is high) and should be written only while the block is idle.
module svpwm_duty_time_calc_core #(
    parameter int FRAC_BITS  = 24,
    parameter int DATA_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  svpwm_pkg::in_item_t    in_item,
    output logic                   out_valid,
    input  logic                   out_ready,
    output svpwm_pkg::out_item_t   out_item,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  svpwm_pkg::cfg_index_t  cfg_index,
    input  logic [31:0]            cfg_data
);
    import svpwm_pkg::*;

    localparam int W = DATA_WIDTH;

    logic [CFG_W-1:0]    period_reg;
    logic [CFG_W-1:0]    gain_reg;
    logic signed [W-1:0] period_w;
    logic signed [W-1:0] gain_w;

    logic         push_valid;
    logic         push_ready;
    queue_entry_t push_entry;
    logic         pop_valid;
    logic         pop_ready;
    queue_entry_t pop_entry;

    assign cfg_ready = 1'b1;
    assign period_w  = W'({1'b0, period_reg});
    assign gain_w    = W'({1'b0, gain_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
            gain_reg   <= GAIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PERIOD: period_reg <= cfg_data[CFG_W-1:0];
                REG_GAIN:   gain_reg   <= cfg_data[CFG_W-1:0];
                default:    ;
            endcase
        end
    end

    svpwm_front #(
        .FRAC_BITS  (FRAC_BITS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    svpwm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    svpwm_back #(
        .FRAC_BITS  (FRAC_BITS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .period_time (period_w),
        .time_gain   (gain_w),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_entry   (pop_entry),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item)
    );

endmodule
